// ----- sv/ffsa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared codes and default sizes for the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_ADDR_BITS    = 16;
    localparam int CFG_W            = 17;

    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_QUERY = 2'd2,
        FN_COUNT = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

endpackage

// ----- sv/ffsa_ifs.sv -----
// ----------------------------------------------------------------------------
// ffsa_ifs
// Request, response and configuration channels of the allocator.
// ----------------------------------------------------------------------------
interface ffsa_req_if #(
    parameter int AW = 16,
    parameter int SW = 17
);
    logic          valid;
    logic          ready;
    logic [1:0]    func;
    logic [SW-1:0] req_size;
    logic [AW-1:0] address;

    modport source (output valid, func, req_size, address, input ready);
    modport sink   (input valid, func, req_size, address, output ready);
endinterface

interface ffsa_rsp_if #(
    parameter int AW = 16,
    parameter int SW = 17,
    parameter int CW = 7
);
    logic          valid;
    logic          ready;
    logic [1:0]    status;
    logic [AW-1:0] alloc_address;
    logic          byte_used;
    logic [CW-1:0] small_count;
    logic [SW-1:0] free_bytes;
    logic [SW-1:0] largest_free;
    logic [CW-1:0] hole_count;

    modport source (output valid, status, alloc_address, byte_used, small_count,
                    free_bytes, largest_free, hole_count, input ready);
    modport sink   (input valid, status, alloc_address, byte_used, small_count,
                    free_bytes, largest_free, hole_count, output ready);
endinterface

interface ffsa_cfg_if #(
    parameter int DW = 17
);
    logic          valid;
    logic          ready;
    logic [DW-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- sv/ffsa_ram.sv -----
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [IW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ffsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer that scans, splits, merges and shifts the segment table in RAM.
// ----------------------------------------------------------------------------
module ffsa_ctrl
    import ffsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int ADDR_BITS    = DEF_ADDR_BITS,
    localparam int AW = ADDR_BITS,
    localparam int SW = ADDR_BITS + 1,
    localparam int IW = $clog2(MAX_SEGMENTS),
    localparam int CW = $clog2(MAX_SEGMENTS + 1),
    localparam int EW = 1 + SW + AW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_init,
    input  logic [SW-1:0] i_pool,
    input  logic          i_req_valid,
    input  logic [1:0]    i_func,
    input  logic [SW-1:0] i_req_size,
    input  logic [AW-1:0] i_address,
    output logic          o_idle,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output logic [1:0]    o_status,
    output logic [AW-1:0] o_alloc_address,
    output logic          o_byte_used,
    output logic [CW-1:0] o_small_count,
    output logic [SW-1:0] o_free_bytes,
    output logic [SW-1:0] o_largest_free,
    output logic [CW-1:0] o_hole_count,
    output logic          o_we,
    output logic [IW-1:0] o_waddr,
    output logic [EW-1:0] o_wdata,
    output logic [IW-1:0] o_raddr,
    input  logic [EW-1:0] i_rdata
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_INIT    = 11'b00000000010,
        S_SCAN    = 11'b00000000100,
        S_FNX_RD  = 11'b00000001000,
        S_FNX_EV  = 11'b00000010000,
        S_MOVE_RD = 11'b00000100000,
        S_MOVE_WR = 11'b00001000000,
        S_FIN_A1  = 11'b00010000000,
        S_FIN_A2  = 11'b00100000000,
        S_FIN_F   = 11'b01000000000,
        S_DONE    = 11'b10000000000
    } t_state;

    t_state        r_state, n_state;
    t_func         r_func, n_func;
    logic [SW-1:0] r_req, n_req;
    logic [AW-1:0] r_addr, n_addr;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_ev_idx, n_ev_idx;
    logic          r_ev_vld, n_ev_vld;
    logic          r_stats, n_stats;
    logic [CW-1:0] r_hit, n_hit;
    logic [EW-1:0] r_prev, n_prev;
    logic [EW-1:0] r_cur, n_cur;
    logic          r_up, n_up;
    logic [CW-1:0] r_dst, n_dst;
    logic [CW-1:0] r_end, n_end;
    logic [1:0]    r_d, n_d;
    logic [CW-1:0] r_fin_idx, n_fin_idx;
    logic [EW-1:0] r_fin_data, n_fin_data;
    logic [1:0]    r_status, n_status;
    logic [AW-1:0] r_aaddr, n_aaddr;
    logic          r_used, n_used;
    logic [CW-1:0] r_small, n_small;
    logic [SW-1:0] r_fb, n_fb;
    logic [SW-1:0] r_lg, n_lg;
    logic [CW-1:0] r_holes, n_holes;

    logic [AW-1:0] e_start, c_start, p_start;
    logic [SW-1:0] e_size, c_size, p_size;
    logic          e_used, p_used;
    logic          hit, scan_end, prev_free, next_free;
    logic [CW-1:0] src, dst_nx;
    logic [SW-1:0] merged;

    assign e_start = i_rdata[AW-1:0];
    assign e_size  = i_rdata[AW+SW-1:AW];
    assign e_used  = i_rdata[EW-1];
    assign c_start = r_cur[AW-1:0];
    assign c_size  = r_cur[AW+SW-1:AW];
    assign p_start = r_prev[AW-1:0];
    assign p_size  = r_prev[AW+SW-1:AW];
    assign p_used  = r_prev[EW-1];

    assign src    = r_up ? (r_dst - CW'(1)) : (r_dst + CW'(r_d));
    assign dst_nx = r_up ? (r_dst - CW'(1)) : (r_dst + CW'(1));

    assign prev_free = (r_hit != '0) && !p_used;
    assign next_free = ((r_hit + CW'(1)) < r_count) && !e_used;
    assign merged    = (prev_free ? p_size : '0) + c_size + (next_free ? e_size : '0);

    always_comb begin
        hit = 1'b0;
        if (!r_stats) begin
            unique case (r_func)
                FN_ALLOC: hit = !e_used && (e_size >= r_req);
                FN_FREE:  hit = (e_start == r_addr);
                FN_QUERY: hit = (r_ev_idx != '0) && (r_addr < e_start);
                FN_COUNT: hit = 1'b0;
            endcase
        end
    end

    assign scan_end = !r_ev_vld && (r_rd_idx >= r_count);

    always_comb begin
        n_state = r_state;   n_func = r_func;     n_req = r_req;
        n_addr = r_addr;     n_count = r_count;   n_rd_idx = r_rd_idx;
        n_ev_idx = r_ev_idx; n_ev_vld = r_ev_vld; n_stats = r_stats;
        n_hit = r_hit;       n_prev = r_prev;     n_cur = r_cur;
        n_up = r_up;         n_dst = r_dst;       n_end = r_end;
        n_d = r_d;           n_fin_idx = r_fin_idx; n_fin_data = r_fin_data;
        n_status = r_status; n_aaddr = r_aaddr;   n_used = r_used;
        n_small = r_small;   n_fb = r_fb;         n_lg = r_lg;
        n_holes = r_holes;
        o_we    = 1'b0;
        o_waddr = r_fin_idx[IW-1:0];
        o_wdata = r_fin_data;
        o_raddr = r_rd_idx[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_init) begin
                    n_state = S_INIT;
                end else if (i_req_valid) begin
                    n_func   = t_func'(i_func);
                    n_req    = i_req_size;
                    n_addr   = i_address;
                    n_status = ST_OK;
                    n_aaddr  = '0;
                    n_used   = 1'b0;
                    n_small  = '0;
                    n_rd_idx = '0;
                    n_ev_vld = 1'b0;
                    n_stats  = 1'b0;
                    n_fb     = '0;
                    n_lg     = '0;
                    n_holes  = '0;
                    n_state  = S_SCAN;
                    if ((t_func'(i_func) == FN_ALLOC) && (i_req_size == '0)) begin
                        n_status = ST_NO_FIT;
                        n_stats  = 1'b1;
                    end
                end
            end
            S_INIT: begin
                o_we    = 1'b1;
                o_waddr = '0;
                o_wdata = {1'b0, i_pool, {AW{1'b0}}};
                n_count = CW'(1);
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (r_rd_idx < r_count) begin
                    n_ev_vld = 1'b1;
                    n_ev_idx = r_rd_idx;
                    n_rd_idx = r_rd_idx + CW'(1);
                end else begin
                    n_ev_vld = 1'b0;
                end
                if (r_ev_vld && hit) begin
                    n_hit = r_ev_idx;
                    n_cur = i_rdata;
                    n_rd_idx = '0;
                    n_ev_vld = 1'b0;
                    n_stats  = 1'b1;
                    unique case (r_func)
                        FN_ALLOC: begin
                            n_aaddr = e_start;
                            if (e_size == r_req) begin
                                n_stats = 1'b0;
                                n_state = S_FIN_A2;
                            end else if (r_count >= CW'(MAX_SEGMENTS)) begin
                                n_status = ST_FULL;
                                n_aaddr  = '0;
                            end else begin
                                n_stats = 1'b0;
                                n_up    = 1'b1;
                                n_dst   = r_count;
                                n_end   = r_ev_idx + CW'(1);
                                n_state = (r_count > r_ev_idx + CW'(1)) ? S_MOVE_RD
                                                                        : S_FIN_A1;
                            end
                        end
                        FN_FREE: begin
                            n_stats = 1'b0;
                            n_state = S_FNX_RD;
                        end
                        default: begin
                            n_used = p_used;
                        end
                    endcase
                end else begin
                    if (r_ev_vld) begin
                        n_prev = i_rdata;
                        if (r_stats) begin
                            if (!e_used) begin
                                n_fb    = r_fb + e_size;
                                n_holes = r_holes + CW'(1);
                                if (e_size > r_lg) begin
                                    n_lg = e_size;
                                end
                            end
                        end else if ((r_func == FN_COUNT) && !e_used && (e_size <= r_req)) begin
                            n_small = r_small + CW'(1);
                        end
                    end
                    if (scan_end) begin
                        n_rd_idx = '0;
                        if (r_stats) begin
                            n_state = S_DONE;
                        end else begin
                            n_stats = 1'b1;
                            unique case (r_func)
                                FN_ALLOC: n_status = ST_NO_FIT;
                                FN_FREE:  n_status = ST_UNKNOWN;
                                FN_QUERY: n_used   = p_used;
                                FN_COUNT: n_status = ST_OK;
                            endcase
                        end
                    end
                end
            end
            S_FNX_RD: begin
                o_raddr = IW'(r_hit + CW'(1));
                n_state = S_FNX_EV;
            end
            S_FNX_EV: begin
                n_fin_idx  = prev_free ? (r_hit - CW'(1)) : r_hit;
                n_fin_data = {1'b0, merged, prev_free ? p_start : c_start};
                n_d        = {1'b0, prev_free} + {1'b0, next_free};
                n_up       = 1'b0;
                n_dst      = (prev_free ? r_hit : (r_hit + CW'(1)));
                n_end      = r_count - CW'({1'b0, prev_free} + {1'b0, next_free});
                n_state    = S_FIN_F;
            end
            S_FIN_F: begin
                o_we = 1'b1;
                if (r_dst < r_end) begin
                    n_state = S_MOVE_RD;
                end else begin
                    n_count = r_end;
                    n_stats = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_MOVE_RD: begin
                o_raddr = src[IW-1:0];
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                o_we    = 1'b1;
                o_waddr = r_dst[IW-1:0];
                o_wdata = i_rdata;
                n_dst   = dst_nx;
                if (r_up ? (dst_nx > r_end) : (dst_nx < r_end)) begin
                    n_state = S_MOVE_RD;
                end else if (r_up) begin
                    n_state = S_FIN_A1;
                end else begin
                    n_count = r_end;
                    n_stats = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_FIN_A1: begin
                o_we    = 1'b1;
                o_waddr = IW'(r_hit + CW'(1));
                o_wdata = {1'b0, c_size - r_req, c_start + r_req[AW-1:0]};
                n_count = r_count + CW'(1);
                n_state = S_FIN_A2;
            end
            S_FIN_A2: begin
                o_we    = 1'b1;
                o_waddr = r_hit[IW-1:0];
                o_wdata = {1'b1, (c_size > r_req) ? r_req : c_size, c_start};
                n_stats = 1'b1;
                n_state = S_SCAN;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_count  <= CW'(1);
            r_ev_vld <= 1'b0;
            r_stats  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ev_vld <= n_ev_vld;
            r_stats  <= n_stats;
        end
        r_func <= n_func;     r_req <= n_req;       r_addr <= n_addr;
        r_rd_idx <= n_rd_idx; r_ev_idx <= n_ev_idx; r_hit <= n_hit;
        r_prev <= n_prev;     r_cur <= n_cur;       r_up <= n_up;
        r_dst <= n_dst;       r_end <= n_end;       r_d <= n_d;
        r_fin_idx <= n_fin_idx; r_fin_data <= n_fin_data;
        r_status <= n_status; r_aaddr <= n_aaddr;   r_used <= n_used;
        r_small <= n_small;   r_fb <= n_fb;         r_lg <= n_lg;
        r_holes <= n_holes;
    end

    assign o_idle          = (r_state == S_IDLE);
    assign o_res_valid     = (r_state == S_DONE);
    assign o_status        = r_status;
    assign o_alloc_address = r_aaddr;
    assign o_byte_used     = r_used;
    assign o_small_count   = r_small;
    assign o_free_bytes    = r_fb;
    assign o_largest_free  = r_lg;
    assign o_hole_count    = r_holes;

endmodule

// ----- sv/first_fit_segment_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit pool allocator over an address-ordered segment table in RAM.
// An operation scans the table for its function, then scans it again for the
// statistics, and shifts entries on a split or merge, all through the single
// RAM read port. One operation is in flight at a time.
// Reset, or a pool size write, writes the single free entry.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator
    import ffsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int ADDR_BITS    = DEF_ADDR_BITS,
    localparam int AW = ADDR_BITS,
    localparam int SW = ADDR_BITS + 1,
    localparam int IW = $clog2(MAX_SEGMENTS),
    localparam int CW = $clog2(MAX_SEGMENTS + 1),
    localparam int EW = 1 + SW + AW,
    localparam int XW = (SW > CFG_W) ? SW : CFG_W
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffsa_req_if.sink    i_req,
    ffsa_rsp_if.source  o_rsp,
    ffsa_cfg_if.sink    i_cfg
);

    logic [SW-1:0] r_pool;
    logic [XW-1:0] cfg_x;
    logic [SW-1:0] cfg_pool;
    logic          idle, cfg_we;
    logic          res_valid, res_ready;
    logic [1:0]    res_status;
    logic [AW-1:0] res_aaddr;
    logic          res_used;
    logic [CW-1:0] res_small, res_holes;
    logic [SW-1:0] res_fb, res_lg;
    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    logic          r_valid;
    logic [1:0]    r_status;
    logic [AW-1:0] r_aaddr;
    logic          r_used;
    logic [CW-1:0] r_small, r_holes;
    logic [SW-1:0] r_fb, r_lg;

    assign cfg_x = XW'(i_cfg.data);
    always_comb begin
        if (cfg_x == '0) begin
            cfg_pool = SW'(1);
        end else if (cfg_x > XW'({1'b1, {AW{1'b0}}})) begin
            cfg_pool = {1'b1, {AW{1'b0}}};
        end else begin
            cfg_pool = cfg_x[SW-1:0];
        end
    end

    assign i_cfg.ready = idle;
    assign cfg_we      = i_cfg.valid && idle;
    assign i_req.ready = idle && !i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= {1'b1, {AW{1'b0}}};
        end else if (cfg_we) begin
            r_pool <= cfg_pool;
        end
    end

    ffsa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_init          (cfg_we),
        .i_pool          (r_pool),
        .i_req_valid     (i_req.valid && i_req.ready),
        .i_func          (i_req.func),
        .i_req_size      (i_req.req_size),
        .i_address       (i_req.address),
        .o_idle          (idle),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_status        (res_status),
        .o_alloc_address (res_aaddr),
        .o_byte_used     (res_used),
        .o_small_count   (res_small),
        .o_free_bytes    (res_fb),
        .o_largest_free  (res_lg),
        .o_hole_count    (res_holes),
        .o_we            (we),
        .o_waddr         (waddr),
        .o_wdata         (wdata),
        .o_raddr         (raddr),
        .i_rdata         (rdata)
    );

    ffsa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGMENTS),
        .IW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign res_ready = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_ready) begin
            r_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_status <= res_status;
            r_aaddr  <= res_aaddr;
            r_used   <= res_used;
            r_small  <= res_small;
            r_fb     <= res_fb;
            r_lg     <= res_lg;
            r_holes  <= res_holes;
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.alloc_address = r_aaddr;
    assign o_rsp.byte_used     = r_used;
    assign o_rsp.small_count   = r_small;
    assign o_rsp.free_bytes    = r_fb;
    assign o_rsp.largest_free  = r_lg;
    assign o_rsp.hole_count    = r_holes;

endmodule
